// ===== src/ptp_pkg.sv =====
// Package for the perspective point transform: payload structs, widths and
// the record that passes from the front part through the queue to the back part.
// No dependencies.
`default_nettype none
package ptp_pkg;

    localparam int COORD_W   = 32;              // Q16.16 coordinate
    localparam int CFG_W     = 64;              // one configuration register
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = 4;               // index port, holds unused codes too
    localparam int TERM_W    = 48;              // floor(p*m / 2^16)
    localparam int ACC_W     = 50;              // exact sum of one column
    localparam int MAG_W     = ACC_W - 1;       // magnitude of an accumulator
    localparam int FRAC_W    = 16;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int DIV_STEPS = COORD_W;         // quotient bits produced

    localparam logic [CFG_IDX_W-1:0] CFG_LAST = CFG_IDX_W'(CFG_NUM - 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      w_zero;
        logic                      saturated;
    } t_result;

    // Matrix element [row][col], two's complement Q16.16.
    typedef logic [3:0][3:0][COORD_W-1:0] t_matrix;

    // Classified item: magnitudes of X, Y, Z, their signs relative to W, magnitude of W and a zero-W flag.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] an;
        logic [2:0]            neg;
        logic [MAG_W-1:0]      ad;
        logic                  wz;
    } t_class;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

// ===== src/ptp_front.sv =====
// Front part: matrix products, column sums and classification of each point.
// Depends on ptp_pkg.
`default_nettype none
module ptp_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ptp_pkg::t_matrix i_matrix,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire ptp_pkg::t_point  i_point,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output ptp_pkg::t_class       o_item
);
    import ptp_pkg::*;

    logic                     r_s1_v, r_s2_v, r_s3_v;
    logic signed [TERM_W-1:0] r_term [4][3];
    logic signed [ACC_W-1:0]  r_acc  [4];
    t_class                   r_item;
    logic                     adv;
    logic signed [COORD_W-1:0] pk [3];
    logic signed [TERM_W-1:0] n_term [4][3];
    logic signed [ACC_W-1:0]  n_acc  [4];
    t_class                   n_item;

    assign adv     = !r_s3_v || !i_q_full;
    assign o_ready = adv;
    assign o_push  = r_s3_v && !i_q_full;
    assign o_item  = r_item;

    assign pk[0] = i_point.point_x;
    assign pk[1] = i_point.point_y;
    assign pk[2] = i_point.point_z;

    always_comb begin
        logic signed [2*COORD_W-1:0] prod;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 3; k++) begin
                prod = pk[k] * $signed(i_matrix[k][c]);
                n_term[c][k] = prod[2*COORD_W-1:FRAC_W];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_acc[c] = ACC_W'($signed(i_matrix[3][c]))
                     + ACC_W'(r_term[c][0]) + ACC_W'(r_term[c][1])
                     + ACC_W'(r_term[c][2]);
        end
    end

    always_comb begin
        logic signed [ACC_W-1:0] a;
        logic                    wneg;
        wneg = r_acc[3][ACC_W-1];
        a = wneg ? -r_acc[3] : r_acc[3];
        n_item.ad = a[MAG_W-1:0];
        n_item.wz = (r_acc[3] == '0);
        for (int c = 0; c < 3; c++) begin
            a = r_acc[c][ACC_W-1] ? -r_acc[c] : r_acc[c];
            n_item.an[c]  = a[MAG_W-1:0];
            n_item.neg[c] = r_acc[c][ACC_W-1] ^ wneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_term <= n_term;
            r_acc  <= n_acc;
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ===== src/ptp_queue.sv =====
// Short queue of classified items between the front and back parts.
// Depends on ptp_pkg.
`default_nettype none
module ptp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ptp_pkg::t_class i_item,
    input  wire logic            i_pop,
    output ptp_pkg::t_class      o_item,
    output ptp_pkg::t_q_status   o_status
);
    import ptp_pkg::*;

    t_class             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_PTR_W:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_status.full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_item;
    end

endmodule
`default_nettype wire

// ===== src/ptp_back.sv =====
// Back part: overflow check, pipelined one-bit-per-stage division of the three
// coordinates by W, clamping and the output register. Depends on ptp_pkg.
`default_nettype none
module ptp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  wire ptp_pkg::t_class i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ptp_pkg::t_result     o_result
);
    import ptp_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0]   rem;
        logic [COORD_W-1:0] qd;   // dividend bits leave at the top, quotient enters
        logic               ov;
        logic               neg;
    } t_lane;

    typedef struct packed {
        logic [2:0] [$bits(t_lane)-1:0] lane;
        logic [MAG_W-1:0]               ad;
        logic                           wz;
    } t_stage;

    logic    en;
    logic    r_v  [DIV_STEPS+1];
    t_stage  r_st [DIV_STEPS+1];
    t_stage  n_st [DIV_STEPS+1];
    logic    r_out_v;
    t_result r_out, n_out;

    assign en       = !r_out_v || i_ready;
    assign o_pop    = en && !i_q_empty;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    // Entry stage: quotient overflows 32 bits when |C| >= |W| * 2^16.
    always_comb begin
        t_lane l;
        n_st[0].ad = i_item.ad;
        n_st[0].wz = i_item.wz;
        for (int c = 0; c < 3; c++) begin
            l.ov  = (i_item.an[c][MAG_W-1:FRAC_W] >= i_item.ad);
            l.neg = i_item.neg[c];
            l.rem = MAG_W'(i_item.an[c][MAG_W-1:FRAC_W]);
            l.qd  = {i_item.an[c][FRAC_W-1:0], {FRAC_W{1'b0}}};
            n_st[0].lane[c] = l;
        end
    end

    always_comb begin
        t_lane             l;
        logic [MAG_W:0]    t;
        logic              b;
        for (int s = 1; s <= DIV_STEPS; s++) begin
            n_st[s].ad = r_st[s-1].ad;
            n_st[s].wz = r_st[s-1].wz;
            for (int c = 0; c < 3; c++) begin
                l = r_st[s-1].lane[c];
                t = {l.rem, l.qd[COORD_W-1]};
                b = (t >= {1'b0, r_st[s-1].ad});
                if (b) t = t - {1'b0, r_st[s-1].ad};
                l.rem = t[MAG_W-1:0];
                l.qd  = {l.qd[COORD_W-2:0], b};
                n_st[s].lane[c] = l;
            end
        end
    end

    always_comb begin
        t_lane              l;
        logic [COORD_W-1:0] lim, mag;
        logic               big, sat;
        logic [2:0][COORD_W-1:0] v;
        sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            l   = r_st[DIV_STEPS].lane[c];
            lim = l.neg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
            big = l.ov || (l.qd > lim);
            mag = big ? lim : l.qd;
            v[c] = l.neg ? (~mag + 1'b1) : mag;
            sat  = sat | big;
        end
        if (r_st[DIV_STEPS].wz) begin
            n_out = '0;
            n_out.w_zero = 1'b1;
        end else begin
            n_out.out_x     = v[0];
            n_out.out_y     = v[1];
            n_out.out_z     = v[2];
            n_out.w_zero    = 1'b0;
            n_out.saturated = sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STEPS; s++) r_v[s] <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_q_empty;
            for (int s = 1; s <= DIV_STEPS; s++) r_v[s] <= r_v[s-1];
            r_out_v <= r_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st  <= n_st;
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// ===== src/point_transform_perspective_unit.sv =====
// Top level of the perspective point transform: configuration registers and
// the front part, queue and back part. Depends on ptp_pkg, ptp_front,
// ptp_queue and ptp_back.
//
//  Channel   Signals                         Direction  Payload
//  -------   ------------------------------  ---------  ----------------------
//  point     i_valid / o_ready / i_point     in         x, y, z (Q16.16)
//  result    o_valid / i_ready / o_result    out        x/w, y/w, z/w, flags
//  config    i_cfg_we / i_cfg_idx / i_cfg_data in       eight 64-bit registers
//
// One point transfer is taken every cycle unless a full queue holds the front part,
// and one result transfer leaves every cycle while the result side is ready. With an
// empty queue a point passes three front stages, the queue, the overflow check stage,
// 32 division stages (one quotient bit per stage) and the output register.
// Reset is synchronous, active low, and loads the identity matrix.
// A stall on the result side freezes the back part only; the front part keeps
// taking points until the four-entry queue is full.
`default_nettype none
module point_transform_perspective_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ptp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ptp_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire ptp_pkg::t_point             i_point,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output ptp_pkg::t_result                 o_result
);
    import ptp_pkg::*;

    logic [CFG_W-1:0] r_cfg [CFG_NUM];
    t_matrix          matrix;
    logic             push, pop;
    t_class           front_item, head_item;
    t_q_status        q_status;

    // Register 2*row holds columns 0 and 1, register 2*row+1 columns 2 and 3;
    // the even column sits in the low half.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                matrix[r][c] = r_cfg[r*2 + c/2][COORD_W*(c%2) +: COORD_W];
            end
        end
    end

    // Writes to an index beyond the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= CFG_W'(64'h0000_0000_0001_0000);
            r_cfg[1] <= '0;
            r_cfg[2] <= CFG_W'(64'h0001_0000_0000_0000);
            r_cfg[3] <= '0;
            r_cfg[4] <= '0;
            r_cfg[5] <= CFG_W'(64'h0000_0000_0001_0000);
            r_cfg[6] <= '0;
            r_cfg[7] <= CFG_W'(64'h0001_0000_0000_0000);
        end else if (i_cfg_we && (i_cfg_idx <= CFG_LAST)) begin
            r_cfg[i_cfg_idx[$clog2(CFG_NUM)-1:0]] <= i_cfg_data;
        end
    end

    ptp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_matrix (matrix),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_point  (i_point),
        .i_q_full (q_status.full),
        .o_push   (push),
        .o_item   (front_item)
    );

    ptp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    ptp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_status.empty),
        .i_item    (head_item),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (o_result)
    );

    // A zero W must give zero coordinates and no saturation flag.
    a_wzero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.w_zero) |->
        (o_result.out_x == '0 && o_result.out_y == '0 && o_result.out_z == '0
         && !o_result.saturated))
        else $error("w_zero result carries nonzero data");

    // The front part never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

    // The back part never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire
